@@ src/glpd_pkg.sv @@
// Shared constants, types and helpers of the grid local peak detector.
package glpd_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int PIXEL_BITS = 8;

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int ROW_BITS = $clog2(MAX_ROWS);
    localparam int DIM_BITS = 7;

    localparam logic [DIM_BITS-1:0] ROWS_RESET = 7'd5;
    localparam logic [DIM_BITS-1:0] COLS_RESET = 7'd5;
    localparam logic [DIM_BITS-1:0] ROWS_LIMIT = DIM_BITS'(MAX_ROWS);
    localparam logic [DIM_BITS-1:0] COLS_LIMIT = DIM_BITS'(MAX_COLS);

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index codes, taken from the word address bit.
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Verdict slots of one job, in the order they leave the block.
    localparam int NUM_SLOTS  = 3;
    localparam int SLOT_ABOVE = 0;
    localparam int SLOT_LEFT  = 1;
    localparam int SLOT_FINAL = 2;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [DIM_BITS-1:0] rows;
        logic [DIM_BITS-1:0] cols;
    } t_grid_cfg;

    // One line store entry: newest row value and the row before it.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] a;
        logic [PIXEL_BITS-1:0] b;
    } t_line_word;

    // Position of the request that made the job, plus up to three verdicts.
    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [NUM_SLOTS-1:0] has;
        logic [NUM_SLOTS-1:0] peak;
    } t_job;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] vmax);
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

@@ src/glpd_front.sv @@
// Front end: raster position, line store and classification of each pixel into verdicts.
module glpd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  glpd_pkg::t_grid_cfg             i_cfg,
    input  logic                            i_restart,
    input  logic                            i_accept,
    input  logic [glpd_pkg::PIXEL_BITS-1:0] i_pixel_value,
    output glpd_pkg::t_job                  o_job,
    output logic                            o_job_push
);

    localparam int DIM_W = glpd_pkg::DIM_BITS;
    localparam int COL_W = glpd_pkg::COL_BITS;
    localparam int ROW_W = glpd_pkg::ROW_BITS;
    localparam int PIX_W = glpd_pkg::PIXEL_BITS;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_nxt_fwd;

    glpd_pkg::t_line_word r_line [glpd_pkg::MAX_COLS];
    glpd_pkg::t_line_word r_mem_q;
    glpd_pkg::t_line_word r_fwd_word;
    glpd_pkg::t_line_word r_cur;
    logic [PIX_W-1:0]     r_prev_px;
    logic [PIX_W-1:0]     r_prev2_px;
    logic [PIX_W-1:0]     r_prev_ctr;

    glpd_pkg::t_line_word nxt_word;
    glpd_pkg::t_line_word wr_word;
    logic [DIM_W-1:0]     rd_sum;
    logic [COL_W-1:0]     rd_addr;
    logic                 col_last;
    logic                 row_last;
    logic [PIX_W-1:0]     ctr;
    logic [PIX_W-1:0]     px;
    logic                 peak_above;
    logic                 peak_left;
    logic                 peak_final;

    assign px       = i_pixel_value;
    assign ctr      = r_cur.a;
    assign col_last = (({1'b0, r_col} + DIM_W'(1)) == i_cfg.cols);
    assign row_last = (({1'b0, r_row} + DIM_W'(1)) == i_cfg.rows);

    // The window holds the current column (r_cur) and the column after it (nxt_word).
    // With one or two columns the word read ahead is the one written now, so it is forwarded.
    assign nxt_word = r_nxt_fwd ? r_fwd_word : r_mem_q;
    assign wr_word  = '{a: px, b: r_cur.a};

    always_comb begin
        rd_sum = {1'b0, r_col} + DIM_W'(2);
        if (rd_sum >= i_cfg.cols) begin
            rd_sum = rd_sum - i_cfg.cols;
        end
        rd_addr = rd_sum[COL_W-1:0];
    end

    always_comb begin
        peak_above = ((r_row < ROW_W'(2)) || (ctr > r_cur.b))
                  && (ctr > px)
                  && ((r_col == '0) || (ctr > r_prev_ctr))
                  && (col_last || (ctr > nxt_word.a));
        peak_left  = ((r_row == '0) || (r_prev_px > r_prev_ctr))
                  && ((r_col < COL_W'(2)) || (r_prev_px > r_prev2_px))
                  && (r_prev_px > px);
        peak_final = ((r_row == '0) || (px > ctr))
                  && ((r_col == '0) || (px > r_prev_px));
    end

    always_comb begin
        o_job.row                           = r_row;
        o_job.col                           = r_col;
        o_job.has[glpd_pkg::SLOT_ABOVE]     = (r_row != '0);
        o_job.has[glpd_pkg::SLOT_LEFT]      = row_last && (r_col != '0);
        o_job.has[glpd_pkg::SLOT_FINAL]     = row_last && col_last;
        o_job.peak[glpd_pkg::SLOT_ABOVE]    = peak_above;
        o_job.peak[glpd_pkg::SLOT_LEFT]     = peak_left;
        o_job.peak[glpd_pkg::SLOT_FINAL]    = peak_final;
        o_job_push                          = i_accept && (o_job.has != '0);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (i_accept) begin
            if (!col_last) begin
                n_col = r_col + COL_W'(1);
            end else begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_nxt_fwd <= 1'b0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            if (i_accept) begin
                r_nxt_fwd <= (i_cfg.cols <= DIM_W'(2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_line[r_col] <= wr_word;
            r_mem_q       <= r_line[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cur      <= (i_cfg.cols == DIM_W'(1)) ? wr_word : nxt_word;
            r_fwd_word <= wr_word;
            r_prev_px  <= px;
            r_prev2_px <= r_prev_px;
            r_prev_ctr <= ctr;
        end
    end

endmodule

@@ src/glpd_queue.sv @@
// Short job queue between the front end and the back end.
module glpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  glpd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output glpd_pkg::t_job o_job,
    output logic           o_avail
);

    localparam int PTR_W = glpd_pkg::Q_PTR_BITS;

    glpd_pkg::t_job   r_slot [glpd_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(glpd_pkg::Q_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ src/glpd_back.sv @@
// Back end: expands each job into its verdicts and holds the result register.
module glpd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  glpd_pkg::t_job                i_job,
    input  logic                          i_job_avail,
    output logic                          o_job_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [glpd_pkg::ROW_BITS-1:0] o_cell_row,
    output logic [glpd_pkg::COL_BITS-1:0] o_cell_col,
    output logic                          o_is_peak,
    output logic                          o_last_of_run,
    output logic                          o_frame_done
);

    localparam int ROW_W = glpd_pkg::ROW_BITS;
    localparam int COL_W = glpd_pkg::COL_BITS;
    localparam int NS    = glpd_pkg::NUM_SLOTS;

    glpd_pkg::t_job  r_job;
    logic [NS-1:0]   r_rem, n_rem;
    logic            r_out_vld;
    logic [ROW_W-1:0] r_cell_row;
    logic [COL_W-1:0] r_cell_col;
    logic            r_is_peak, r_last, r_done;

    logic            can_load, emit;
    logic [NS-1:0]   sel, rem_after;
    logic [ROW_W-1:0] sel_row;
    logic [COL_W-1:0] sel_col;
    logic            sel_peak, sel_done;

    assign can_load = !r_out_vld || i_pop;
    assign emit     = can_load && (r_rem != '0);

    // Verdicts leave in raster order: cell above, cell to the left, final cell.
    always_comb begin
        sel      = '0;
        sel_row  = r_job.row;
        sel_col  = r_job.col;
        sel_peak = r_job.peak[glpd_pkg::SLOT_FINAL];
        sel_done = 1'b0;
        if (r_rem[glpd_pkg::SLOT_ABOVE]) begin
            sel[glpd_pkg::SLOT_ABOVE] = 1'b1;
            sel_row  = r_job.row - ROW_W'(1);
            sel_peak = r_job.peak[glpd_pkg::SLOT_ABOVE];
        end else if (r_rem[glpd_pkg::SLOT_LEFT]) begin
            sel[glpd_pkg::SLOT_LEFT] = 1'b1;
            sel_col  = r_job.col - COL_W'(1);
            sel_peak = r_job.peak[glpd_pkg::SLOT_LEFT];
        end else begin
            sel[glpd_pkg::SLOT_FINAL] = 1'b1;
            sel_done = 1'b1;
        end
        rem_after = r_rem & ~sel;
    end

    always_comb begin
        o_job_take = i_job_avail && ((r_rem == '0) || (emit && (rem_after == '0)));
        n_rem = r_rem;
        if (o_job_take) begin
            n_rem = i_job.has;
        end else if (emit) begin
            n_rem = rem_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rem <= n_rem;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_cell_row <= sel_row;
            r_cell_col <= sel_col;
            r_is_peak  <= sel_peak;
            r_last     <= (rem_after == '0);
            r_done     <= sel_done;
        end
    end

    assign o_empty       = !r_out_vld;
    assign o_cell_row    = r_cell_row;
    assign o_cell_col    = r_cell_col;
    assign o_is_peak     = r_is_peak;
    assign o_last_of_run = r_last;
    assign o_frame_done  = r_done;

endmodule

@@ src/grid_local_peak_detector_unit.sv @@
// Top level of the grid local peak detector: configuration registers, front, queue and back.
//
//   channel   direction  request moves on          payload
//   pixels    in         push & !full              i_pixel_value
//   verdicts  out        pop & !empty              o_cell_row, o_cell_col, o_is_peak,
//                                                  o_last_of_run, o_frame_done
//   config    in/out     psel & penable & pwrite   pwdata, paddr (rows at 0, cols at 4)
//
// The front end takes one pixel per cycle while full is low; each pixel becomes a job of zero
// to three verdicts. The back end delivers one verdict per cycle while pop is high, so the last
// row (up to three verdicts per pixel) sets the sustained rate: one pixel per cycle above it,
// fewer in that row.
// A four-entry job queue lets the front run ahead while results wait; full rises when it fills.
// Reset is synchronous; the line store needs no clearing pass and the block is ready at once.
// A register write restarts the frame at row 0, column 0.
module grid_local_peak_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [glpd_pkg::PIXEL_BITS-1:0]      i_pixel_value,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [glpd_pkg::ROW_BITS-1:0]        o_cell_row,
    output logic [glpd_pkg::COL_BITS-1:0]        o_cell_col,
    output logic                                 o_is_peak,
    output logic                                 o_last_of_run,
    output logic                                 o_frame_done,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [glpd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [glpd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [glpd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int DIM_W  = glpd_pkg::DIM_BITS;
    localparam int DATA_W = glpd_pkg::APB_DATA_BITS;

    glpd_pkg::t_grid_cfg r_cfg;
    logic                cfg_wr;
    logic                reg_idx;
    logic [DIM_W-1:0]    wr_dim;

    logic                accept;
    glpd_pkg::t_job      front_job;
    logic                front_push;
    glpd_pkg::t_job      q_job;
    logic                q_full;
    logic                q_avail;
    logic                back_take;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign wr_dim  = pwdata[DIM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= glpd_pkg::ROWS_RESET;
            r_cfg.cols <= glpd_pkg::COLS_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                glpd_pkg::REG_GRID_ROWS: begin
                    r_cfg.rows <= glpd_pkg::clamp_dim(wr_dim, glpd_pkg::ROWS_LIMIT);
                end
                glpd_pkg::REG_GRID_COLS: begin
                    r_cfg.cols <= glpd_pkg::clamp_dim(wr_dim, glpd_pkg::COLS_LIMIT);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            glpd_pkg::REG_GRID_ROWS: prdata = DATA_W'(r_cfg.rows);
            glpd_pkg::REG_GRID_COLS: prdata = DATA_W'(r_cfg.cols);
            default:                 prdata = '0;
        endcase
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    glpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_restart     (cfg_wr),
        .i_accept      (accept),
        .i_pixel_value (i_pixel_value),
        .o_job         (front_job),
        .o_job_push    (front_push)
    );

    glpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_take),
        .o_job   (q_job),
        .o_avail (q_avail)
    );

    glpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (q_job),
        .i_job_avail   (q_avail),
        .o_job_take    (back_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_is_peak     (o_is_peak),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // The end-of-frame verdict always closes the run of the pixel that caused it.
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_done) |-> o_last_of_run)
        else $error("frame_done without last_of_run");

    // The end-of-frame verdict belongs to the bottom-right cell of the configured grid.
    a_done_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_done) |->
            (({1'b0, o_cell_row} + DIM_W'(1)) == r_cfg.rows) &&
            (({1'b0, o_cell_col} + DIM_W'(1)) == r_cfg.cols))
        else $error("frame_done on a cell other than the last one");

    // Every delivered verdict lies inside the configured grid.
    a_cell_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ({1'b0, o_cell_col} < r_cfg.cols) && ({1'b0, o_cell_row} < r_cfg.rows))
        else $error("verdict for a cell outside the grid");

endmodule

@@ sim/tb_grid_local_peak_detector_unit.sv @@
// Self-checking testbench for the grid local peak detector: fixed and random frames vs. a predictor.
module tb_grid_local_peak_detector_unit;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 60;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [glpd_pkg::ROW_BITS-1:0] row;
        logic [glpd_pkg::COL_BITS-1:0] col;
        logic                          peak;
        logic                          last;
        logic                          done;
    } t_cell_verdict;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    logic [glpd_pkg::PIXEL_BITS-1:0]    i_pixel_value = '0;
    logic                               pop = 1'b0;
    logic                               empty;
    logic [glpd_pkg::ROW_BITS-1:0]      o_cell_row;
    logic [glpd_pkg::COL_BITS-1:0]      o_cell_col;
    logic                               o_is_peak;
    logic                               o_last_of_run;
    logic                               o_frame_done;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [glpd_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [glpd_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [glpd_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    // Predictor state: grid size in use, position of the next pixel, two rows of history.
    int                              frame_rows = 5;
    int                              frame_cols = 5;
    int                              next_row = 0;
    int                              next_col = 0;
    logic [glpd_pkg::PIXEL_BITS-1:0] last_pixel = '0;
    logic [glpd_pkg::PIXEL_BITS-1:0] line_new [glpd_pkg::MAX_COLS] = '{default: '0};
    logic [glpd_pkg::PIXEL_BITS-1:0] line_old [glpd_pkg::MAX_COLS] = '{default: '0};

    t_cell_verdict pending_verdicts[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            stall_left = 0;

    grid_local_peak_detector_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random, or for a counted stretch when one is requested.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cell_verdict want;
        t_cell_verdict got;
        if (i_rst_n && pop && !empty) begin
            got = '{o_cell_row, o_cell_col, o_is_peak, o_last_of_run, o_frame_done};
            if (pending_verdicts.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected verdict row %0d col %0d peak %0d last %0d done %0d",
                             got.row, got.col, got.peak, got.last, got.done);
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"ERROR: verdict mismatch: expected row %0d col %0d peak %0d",
                                  " last %0d done %0d, got row %0d col %0d peak %0d last %0d",
                                  " done %0d"},
                                 want.row, want.col, want.peak, want.last, want.done,
                                 got.row, got.col, got.peak, got.last, got.done);
                end
            end
        end
    end

    function automatic int fit_dim(input logic [glpd_pkg::APB_DATA_BITS-1:0] value,
                                   input int limit);
        int v;
        v = int'(value[glpd_pkg::DIM_BITS-1:0]);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // Works out the verdicts that one accepted pixel releases, in raster order of the cells.
    task automatic judge_pixel(input logic [glpd_pkg::PIXEL_BITS-1:0] px);
        int                              r;
        int                              c;
        bit                              last_row;
        bit                              pk;
        logic [glpd_pkg::PIXEL_BITS-1:0] ctr;
        t_cell_verdict                   run[$];
        r = next_row;
        c = next_col;
        last_row = (r + 1 == frame_rows);
        if (r >= frame_rows || c >= frame_cols) begin
            r = 0;
            c = 0;
            last_row = (frame_rows == 1);
        end
        // The cell above is complete once this pixel below it arrives.
        if (r >= 1) begin
            ctr = line_new[c];
            pk = (r < 2 || ctr > line_old[c]) && ctr > px
                 && (c == 0 || ctr > line_old[c - 1])
                 && (c + 1 >= frame_cols || ctr > line_new[c + 1]);
            run.push_back('{glpd_pkg::ROW_BITS'(r - 1), glpd_pkg::COL_BITS'(c),
                            pk, 1'b0, 1'b0});
        end
        line_old[c] = line_new[c];
        line_new[c] = px;
        if (last_row && c > 0) begin
            ctr = last_pixel;
            pk = (r == 0 || ctr > line_old[c - 1])
                 && (c < 2 || ctr > line_new[c - 2]) && ctr > px;
            run.push_back('{glpd_pkg::ROW_BITS'(r), glpd_pkg::COL_BITS'(c - 1),
                            pk, 1'b0, 1'b0});
        end
        if (last_row && c + 1 == frame_cols) begin
            pk = (r == 0 || px > line_old[c]) && (c == 0 || px > line_new[c - 1]);
            run.push_back('{glpd_pkg::ROW_BITS'(r), glpd_pkg::COL_BITS'(c), pk, 1'b0, 1'b1});
        end
        last_pixel = px;
        if (c + 1 < frame_cols) begin
            next_col = c + 1;
            next_row = r;
        end else if (r + 1 < frame_rows) begin
            next_col = 0;
            next_row = r + 1;
        end else begin
            next_col = 0;
            next_row = 0;
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            pending_verdicts.push_back(run[i]);
    endtask

    task automatic send_pixel(input logic [glpd_pkg::PIXEL_BITS-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_pixel_value <= value;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        judge_pixel(value);
    endtask

    // Waits until every predicted verdict has come out and the block has gone quiet.
    task automatic drain_block();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel,
                             input logic [glpd_pkg::APB_DATA_BITS-1:0] value);
        drain_block();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_sel == glpd_pkg::REG_GRID_ROWS)
            frame_rows = fit_dim(value, glpd_pkg::MAX_ROWS);
        else
            frame_cols = fit_dim(value, glpd_pkg::MAX_COLS);
        next_row = 0;
        next_col = 0;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper data bits are random; only the low bits of a register count.
    task automatic set_grid(input int rows, input int cols);
        write_reg(glpd_pkg::REG_GRID_ROWS,
                  ($urandom() & ~32'h7f) | glpd_pkg::APB_DATA_BITS'(rows));
        write_reg(glpd_pkg::REG_GRID_COLS,
                  ($urandom() & ~32'h7f) | glpd_pkg::APB_DATA_BITS'(cols));
    endtask

    function automatic logic [glpd_pkg::PIXEL_BITS-1:0] pick_pixel(input bit narrow);
        return narrow ? glpd_pkg::PIXEL_BITS'($urandom_range(3))
                      : glpd_pkg::PIXEL_BITS'($urandom_range(255));
    endfunction

    // Hand-made 5x5 frame on the reset grid size: corner, edge and interior peaks, ties, extremes.
    task automatic test_reset_grid();
        logic [glpd_pkg::PIXEL_BITS-1:0] frame [25] = '{
            8'd255, 8'd0,   8'd7,   8'd7,   8'd9,
            8'd0,   8'd3,   8'd1,   8'd8,   8'd2,
            8'd4,   8'd9,   8'd0,   8'd255, 8'd255,
            8'd2,   8'd0,   8'd6,   8'd1,   8'd3,
            8'd200, 8'd1,   8'd0,   8'd4,   8'd255};
        foreach (frame[i])
            send_pixel(frame[i]);
    endtask

    // Zero acts as one and oversized values act as the maximum.
    task automatic test_grid_extremes();
        set_grid(0, 0);
        repeat (3) send_pixel(pick_pixel(1'b0));
        set_grid(127, 1);
        repeat (glpd_pkg::MAX_ROWS) send_pixel(pick_pixel(1'b0));
        set_grid(2, 65);
        repeat (2 * glpd_pkg::MAX_COLS) send_pixel(pick_pixel(1'b0));
    endtask

    // The receiver holds off while pixels keep coming, so the job queue fills and full rises.
    task automatic test_backpressure();
        set_grid(4, 6);
        stall_left = HOLD_CYCLES;
        repeat (24) send_pixel(pick_pixel(1'b0));
    endtask

    task automatic test_random_frames();
        int sent;
        int n;
        bit narrow;
        bit broken;
        broken = 1'b0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                // A cut-off frame is always followed by a fresh grid size.
                case (broken ? 0 : $urandom_range(3))
                    0: set_grid($urandom_range(1, 8), $urandom_range(1, 8));
                    1: write_reg(glpd_pkg::REG_GRID_ROWS,
                                 glpd_pkg::APB_DATA_BITS'($urandom_range(1, 8)));
                    2: write_reg(glpd_pkg::REG_GRID_COLS,
                                 glpd_pkg::APB_DATA_BITS'($urandom_range(1, 8)));
                    default: ;
                endcase
                n = frame_rows * frame_cols;
                broken = (n > 1 && $urandom_range(4) == 0);
                if (broken)
                    n = $urandom_range(1, n - 1);
                narrow = $urandom_range(1);
                repeat (n) send_pixel(pick_pixel(narrow));
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_grid();
        test_grid_extremes();
        test_backpressure();
        test_random_frames();
        drain_block();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
